### rtl/md5_pkg.sv
// Package for the MD5 digest core: sequencer states, word types and round tables.
// No dependencies; imported by md5_round and md5_message_digest_core.
`timescale 1ns / 1ps

package md5_pkg;

  typedef logic [3:0][31:0] word4_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_PAD,
    S_OUT0,
    S_OUT1
  } state_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [5:0] LAST_RND  = 6'd63;
  localparam logic [3:0] LEN_LO_W  = 4'd14;
  localparam logic [3:0] LEN_HI_W  = 4'd15;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // rotate amount depends on the quarter and the round number mod 4
  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] r;
    unique case ({i[5:4], i[1:0]})
      4'd0:  r = 5'd7;  4'd1:  r = 5'd12; 4'd2:  r = 5'd17; 4'd3:  r = 5'd22;
      4'd4:  r = 5'd5;  4'd5:  r = 5'd9;  4'd6:  r = 5'd14; 4'd7:  r = 5'd20;
      4'd8:  r = 5'd4;  4'd9:  r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; 4'd15: r = 5'd21;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // message word used by round i
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] n;
    logic [3:0] g;
    n = i[3:0];
    unique case (i[5:4])
      2'd0: g = n;
      2'd1: g = 4'(n * 4'd5 + 4'd1);
      2'd2: g = 4'(n * 4'd3 + 4'd5);
      2'd3: g = 4'(n * 4'd7);
      default: g = n;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

### rtl/md5_round.sv
// One MD5 round step: boolean function, four-way add, rotate and word shuffle.
// Uses md5_pkg for word4_t and the round constant and rotate tables.
`timescale 1ns / 1ps

module md5_round
  import md5_pkg::*;
(
  input  logic [5:0]  idx,
  input  word4_t      words_in,
  input  logic [31:0] msg_word,
  output word4_t      words_out
);

  logic [31:0] a, b, c, d;
  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] dbl;
  logic [31:0] rot;

  assign a = words_in[0];
  assign b = words_in[1];
  assign c = words_in[2];
  assign d = words_in[3];

  always_comb begin
    unique case (idx[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
  end

  assign sum = f + a + round_k(idx) + msg_word;
  // rotate left through a doubled word
  assign dbl = {sum, sum} << rot_amt(idx);
  assign rot = dbl[63:32];

  assign words_out[0] = d;
  assign words_out[1] = b + rot;
  assign words_out[2] = b;
  assign words_out[3] = c;

endmodule

### rtl/md5_message_digest_core.sv
// MD5 digest core top level: byte collection, padding sequencer and chaining.
// Depends on md5_pkg and md5_round.
`timescale 1ns / 1ps

// Message bytes arrive one per input transaction, low byte of each word first. A byte that
// does not complete a 64-byte block is taken without holding off the input. The byte that
// completes a block is taken, and input is then held off while the block runs 64 rounds
// through the single shared round unit, one per cycle, and is added into the chaining words.
// An end-of-message transaction starts padding, which writes one pad byte per cycle up to
// byte 56 of the block (crossing into an extra block when fewer than nine bytes were free),
// then loads the bit length and runs the last block. The digest leaves as two 64-bit output
// transactions, first half first; no input is taken until both have gone, after which the
// core is back in its reset state for the next message.
module md5_message_digest_core
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_half,
  output logic        is_last
);

  state_t      state, state_next;
  logic [5:0]  round_idx;
  word4_t      chain_words;
  word4_t      round_words;
  word4_t      round_out;
  logic [31:0] block_words [16];
  logic [5:0]  count;
  logic [63:0] bit_len;
  logic        finishing;
  logic        final_block;
  logic        pad_80;

  logic        in_take;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic        len_wr;
  logic        round_start;
  logic        done;

  md5_round u_round (
    .idx       (round_idx),
    .words_in  (round_words),
    .msg_word  (block_words[msg_index(round_idx)]),
    .words_out (round_out)
  );

  assign in_take     = in_valid && in_ready;
  assign round_start = (state_next == S_ROUND) && (state != S_ROUND);
  assign done        = (state == S_OUT1) && out_ready;

  // outputs of the sequencer
  always_comb begin
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT0) || (state == S_OUT1);
    is_last   = (state == S_OUT1);
    wr_en     = 1'b0;
    wr_byte   = data_byte;
    len_wr    = 1'b0;
    unique case (state)
      S_IDLE: wr_en = in_valid && has_byte;
      S_PAD: begin
        len_wr  = pad_80 && (count == LEN_POS);
        wr_en   = !len_wr;
        wr_byte = pad_80 ? 8'h00 : PAD_MARK;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (has_byte && count == LAST_POS) state_next = S_ROUND;
          else if (end_of_message)           state_next = S_PAD;
        end
      end
      S_ROUND: if (round_idx == LAST_RND) state_next = S_ADD;
      S_ADD: begin
        if (!finishing)      state_next = S_IDLE;
        else if (final_block) state_next = S_OUT0;
        else                 state_next = S_PAD;
      end
      S_PAD: if (len_wr || count == LAST_POS) state_next = S_ROUND;
      S_OUT0: if (out_ready) state_next = S_OUT1;
      S_OUT1: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || done) begin
      state       <= S_IDLE;
      chain_words <= {INIT_D, INIT_C, INIT_B, INIT_A};
      round_words <= '0;
      round_idx   <= '0;
      count       <= '0;
      bit_len     <= '0;
      finishing   <= 1'b0;
      final_block <= 1'b0;
      pad_80      <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) count <= count + 6'd1;
      if (in_take && has_byte) bit_len <= bit_len + 64'd8;
      if (in_take && end_of_message) finishing <= 1'b1;
      if (state == S_PAD && wr_en) pad_80 <= 1'b1;
      if (len_wr) final_block <= 1'b1;
      if (round_start) begin
        round_words <= chain_words;
        round_idx   <= '0;
      end else if (state == S_ROUND) begin
        round_words <= round_out;
        round_idx   <= round_idx + 6'd1;
      end
      if (state == S_ADD) begin
        for (int i = 0; i < 4; i++) chain_words[i] <= chain_words[i] + round_words[i];
      end
    end
  end

  // block store: a byte in lane 0 clears the rest of its word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (count[1:0] == 2'd0) block_words[count[5:2]] <= {24'h0, wr_byte};
      else block_words[count[5:2]][{count[1:0], 3'b000} +: 8] <= wr_byte;
    end
    if (len_wr) begin
      block_words[LEN_LO_W] <= bit_len[31:0];
      block_words[LEN_HI_W] <= bit_len[63:32];
    end
  end

  assign digest_half = (state == S_OUT1)
                     ? {bswap32(chain_words[2]), bswap32(chain_words[3])}
                     : {bswap32(chain_words[0]), bswap32(chain_words[1])};

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while digest pending");

  a_round_start: assert property (@(posedge clk) disable iff (rst)
    round_start |=> (round_idx == 6'd0) && (state == S_ROUND))
    else $error("round counter not cleared at block start");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round_idx == LAST_RND) |=> (state == S_ADD))
    else $error("block did not end after 64 rounds");

  a_len_pos: assert property (@(posedge clk) disable iff (rst)
    len_wr |-> (count == LEN_POS) && pad_80 && finishing)
    else $error("length written at wrong place");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (count == 6'd0) && (chain_words[0] == INIT_A) && (bit_len == 64'd0))
    else $error("reset state wrong");

endmodule
